FILE: src/opa_pkg.sv
// Shared types, widths and codes for the outer-product accumulator.
// Used by every module of the block except opa_ram; depends on nothing else.
`timescale 1ns / 1ps

package opa_pkg;

  // Default geometry.
  localparam int unsigned DIM_DEFAULT         = 64;
  localparam int unsigned NUM_VECTORS_DEFAULT = 64;

  // Fixed field widths.
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned ENTRY_W  = 8;
  localparam int unsigned ELEM_W   = 6;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned COLS_W   = 7;

  // Width for range compares against the geometry (holds up to 2047).
  localparam int unsigned IDX_W    = 11;
  // Width for flat address arithmetic before truncation to a memory index.
  localparam int unsigned ADDR_FULL_W = 21;

  // Configuration port.
  localparam int unsigned APB_AW = 2;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_COLUMNS_IN_USE = 2'd0;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_TABLE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_ROW   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ACCUMULATE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ_CELL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

  // Saturation bounds of an accumulator cell.
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Status of the multiply-accumulate pipeline, seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic sat;
  } mac_status_t;

endpackage

FILE: src/opa_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Generic storage for the block; depends on no other file.
`timescale 1ns / 1ps

module opa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/opa_regs.sv
// APB-style configuration register file holding columns_in_use.
// Depends on opa_pkg for widths and register addresses.
`timescale 1ns / 1ps

module opa_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [opa_pkg::APB_AW-1:0]   paddr,
  input  logic [opa_pkg::APB_DW-1:0]   pwdata,
  output logic [opa_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic [opa_pkg::COLS_W-1:0]   columns_in_use_o
);

  logic [opa_pkg::COLS_W-1:0] cols_q;
  logic [opa_pkg::COLS_W-1:0] cols_d;
  logic                       hit;
  logic                       wr_en;

  assign pready = 1'b1;
  assign hit    = (paddr == opa_pkg::REG_COLUMNS_IN_USE);
  assign wr_en  = psel && penable && pwrite && pready && hit;

  // Register update on the access phase of a write transfer.
  always_comb begin
    cols_d = cols_q;
    if (wr_en) begin
      cols_d = pwdata[opa_pkg::COLS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= '0;
    end else begin
      cols_q <= cols_d;
    end
  end

  // Read data; unmapped addresses read as zero.
  assign prdata = hit ? {{(opa_pkg::APB_DW-opa_pkg::COLS_W){1'b0}}, cols_q} : '0;

  assign columns_in_use_o = cols_q;

endmodule

FILE: src/opa_mac.sv
// Multiply-accumulate pipeline for the rank-one update: product, then a
// saturating read-modify-write of one accumulator cell. Depends on opa_pkg.
`timescale 1ns / 1ps

module opa_mac #(
  parameter int unsigned AW = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Issue stage: cell whose operands were read from the vector memories.
  input  logic                                issue_i,
  input  logic [AW-1:0]                       cell_i,
  // Operands, valid in the cycle after issue.
  input  logic [opa_pkg::SAMPLE_W-1:0]        row_data_i,
  input  logic [opa_pkg::SAMPLE_W-1:0]        vec_data_i,
  // Accumulator memory access.
  output logic [AW-1:0]                       acc_raddr_o,
  input  logic [opa_pkg::ACC_W-1:0]           acc_rdata_i,
  output logic                                acc_we_o,
  output logic [AW-1:0]                       acc_waddr_o,
  output logic [opa_pkg::ACC_W-1:0]           acc_wdata_o,
  output opa_pkg::mac_status_t                status_o
);

  localparam int unsigned PW = opa_pkg::PROD_W;
  localparam int unsigned AccW = opa_pkg::ACC_W;

  logic                 s1_valid_q;
  logic [AW-1:0]        s1_cell_q;
  logic                 s2_valid_q;
  logic [AW-1:0]        s2_cell_q;
  logic signed [PW-1:0] prod_d;
  logic signed [PW-1:0] prod_q;
  logic [AccW:0]        sum;
  logic                 ovf;

  // Stage 1: operands arrive, form the exact Q16.16 product.
  assign prod_d = $signed(row_data_i) * $signed(vec_data_i);

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    s1_cell_q <= cell_i;
    s2_cell_q <= s1_cell_q;
    prod_q    <= prod_d;
  end

  // The accumulator read is issued in stage 1 so its data meets the product.
  assign acc_raddr_o = s1_cell_q;

  // Stage 2: saturating add and write back.
  assign sum = {acc_rdata_i[AccW-1], acc_rdata_i}
             + {{(AccW+1-PW){prod_q[PW-1]}}, prod_q};
  assign ovf = (sum[AccW] != sum[AccW-1]);

  always_comb begin
    if (!ovf) begin
      acc_wdata_o = sum[AccW-1:0];
    end else if (sum[AccW]) begin
      acc_wdata_o = opa_pkg::ACC_MIN;
    end else begin
      acc_wdata_o = opa_pkg::ACC_MAX;
    end
  end

  assign acc_we_o    = s2_valid_q;
  assign acc_waddr_o = s2_cell_q;

  assign status_o.busy = s1_valid_q || s2_valid_q;
  assign status_o.sat  = s2_valid_q && ovf;

endmodule

FILE: src/outer_product_accumulator_unit.sv
// Outer-product accumulator: item decode, sequencer and memory muxing.
// Depends on opa_pkg, opa_ram, opa_regs and opa_mac.
//
// Usage. Items enter on the in channel (valid/ready) and each gives exactly
// one result on the out channel (valid/ready). The user is to write
// columns_in_use over the APB-style port only while the block is idle; the
// block does not enforce this. pready is always high. Loads of table or row
// elements, out-of-range items and unused codes give their result in the
// cycle after the transfer. A cell read is answered from the ST_READ state.
// An accumulate item streams all DIM*DIM cells through the accumulator memory,
// one multiply-accumulate per cycle; the single read/write port pair of that
// memory sets this rate. A clear writes zero to every cell.
// Items are handled one at a time. A finished result sits in an output
// register; the next item is taken as soon as that register is empty or is
// being drained in the same cycle, so a stalled receiver holds the result
// and blocks only new items.
// After reset the accumulator is zeroed by a sweep over all DIM*DIM cells,
// during which in_ready_o stays low; configuration writes are taken throughout.
`timescale 1ns / 1ps

module outer_product_accumulator_unit #(
  parameter int unsigned DIM         = opa_pkg::DIM_DEFAULT,
  parameter int unsigned NUM_VECTORS = opa_pkg::NUM_VECTORS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [opa_pkg::APB_AW-1:0]           paddr,
  input  logic [opa_pkg::APB_DW-1:0]           pwdata,
  output logic [opa_pkg::APB_DW-1:0]           prdata,
  output logic                                 pready,
  // Input items.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [opa_pkg::FUNC_W-1:0]           func_i,
  input  logic [opa_pkg::ENTRY_W-1:0]          table_entry_i,
  input  logic [opa_pkg::ELEM_W-1:0]           elem_a_i,
  input  logic [opa_pkg::ELEM_W-1:0]           elem_b_i,
  input  logic signed [opa_pkg::SAMPLE_W-1:0]  sample_i,
  // Results.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [opa_pkg::STATUS_W-1:0]         status_o,
  output logic signed [opa_pkg::ACC_W-1:0]     read_value_o
);

  localparam int unsigned ROW_AW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned TAB_DEPTH = NUM_VECTORS * DIM;
  localparam int unsigned TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
  localparam int unsigned ACC_DEPTH = DIM * DIM;
  localparam int unsigned ACC_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam int unsigned IW        = opa_pkg::IDX_W;
  localparam int unsigned AFW       = opa_pkg::ADDR_FULL_W;
  localparam int unsigned SW        = opa_pkg::SAMPLE_W;
  localparam int unsigned AccW      = opa_pkg::ACC_W;
  localparam int unsigned StW       = opa_pkg::STATUS_W;

  typedef logic [IW-1:0]  idx_t;
  typedef logic [AFW-1:0] afull_t;

  // Sequencer states.
  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [ACC_AW-1:0]         cell_q, cell_d;
  logic [ROW_AW-1:0]         j_q, j_d;
  logic [ROW_AW-1:0]         k_q, k_d;
  logic [TAB_AW-1:0]         base_q, base_d;
  logic                      sat_q, sat_d;
  logic                      out_valid_q, out_valid_d;
  logic [StW-1:0]            out_status_q, out_status_d;
  logic [AccW-1:0]           out_value_q, out_value_d;

  logic [opa_pkg::COLS_W-1:0] columns_in_use;
  logic                      in_accept;
  logic                      out_free;
  logic                      cell_last;
  logic                      k_last;
  logic                      sweep;
  idx_t                      nv_lim;
  idx_t                      dim_lim;
  idx_t                      cols_ext;
  idx_t                      acc_lim;
  logic                      entry_oor;
  logic                      ea_oor;
  logic                      eb_oor;
  logic                      acc_oor;
  afull_t                    base_full;
  afull_t                    tab_full;
  afull_t                    cell_full;

  logic                      tab_we;
  logic [TAB_AW-1:0]         tab_raddr;
  logic [SW-1:0]             tab_rdata;
  logic                      row_we;
  logic [SW-1:0]             row_rdata;
  logic                      acc_we;
  logic [ACC_AW-1:0]         acc_waddr;
  logic [AccW-1:0]           acc_wdata;
  logic [ACC_AW-1:0]         acc_raddr;
  logic [AccW-1:0]           acc_rdata;

  logic [ACC_AW-1:0]         mac_raddr;
  logic                      mac_we;
  logic [ACC_AW-1:0]         mac_waddr;
  logic [AccW-1:0]           mac_wdata;
  opa_pkg::mac_status_t      mac_st;

  // Configuration registers.
  opa_regs u_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .columns_in_use_o (columns_in_use)
  );

  // Handshake.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  // Range checks of the incoming item.
  assign nv_lim    = idx_t'(NUM_VECTORS);
  assign dim_lim   = idx_t'(DIM);
  assign cols_ext  = idx_t'(columns_in_use);
  assign acc_lim   = (cols_ext < nv_lim) ? cols_ext : nv_lim;
  assign entry_oor = idx_t'(table_entry_i) >= nv_lim;
  assign ea_oor    = idx_t'(elem_a_i) >= dim_lim;
  assign eb_oor    = idx_t'(elem_b_i) >= dim_lim;
  assign acc_oor   = idx_t'(table_entry_i) >= acc_lim;

  // Flat addresses; the multiplier is shared by table loads and accumulate setup.
  assign base_full = afull_t'(table_entry_i) * afull_t'(DIM);
  assign tab_full  = base_full + afull_t'(elem_a_i);
  assign cell_full = afull_t'(elem_a_i) * afull_t'(DIM) + afull_t'(elem_b_i);

  assign cell_last = (cell_q == ACC_AW'(ACC_DEPTH - 1));
  assign k_last    = (k_q == ROW_AW'(DIM - 1));
  assign sweep     = (state_q == ST_INIT) || (state_q == ST_CLEAR);

  // Sequencer and result register.
  always_comb begin
    state_d      = state_q;
    cell_d       = cell_q;
    j_d          = j_q;
    k_d          = k_q;
    base_d       = base_q;
    sat_d        = sat_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    tab_we       = 1'b0;
    row_we       = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        cell_d = cell_q + 1'b1;
        if (cell_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          out_status_d = opa_pkg::STATUS_OK;
          out_value_d  = '0;
          unique case (func_i)
            opa_pkg::FUNC_LOAD_TABLE: begin
              out_valid_d = 1'b1;
              if (entry_oor || ea_oor) begin
                out_status_d = opa_pkg::STATUS_RANGE;
              end else begin
                tab_we = 1'b1;
              end
            end
            opa_pkg::FUNC_LOAD_ROW: begin
              out_valid_d = 1'b1;
              if (ea_oor) begin
                out_status_d = opa_pkg::STATUS_RANGE;
              end else begin
                row_we = 1'b1;
              end
            end
            opa_pkg::FUNC_ACCUMULATE: begin
              if (acc_oor) begin
                out_valid_d  = 1'b1;
                out_status_d = opa_pkg::STATUS_RANGE;
              end else begin
                state_d = ST_MAC;
                cell_d  = '0;
                j_d     = '0;
                k_d     = '0;
                base_d  = base_full[TAB_AW-1:0];
                sat_d   = 1'b0;
              end
            end
            opa_pkg::FUNC_READ_CELL: begin
              if (ea_oor || eb_oor) begin
                out_valid_d  = 1'b1;
                out_status_d = opa_pkg::STATUS_RANGE;
              end else begin
                state_d = ST_READ;
              end
            end
            opa_pkg::FUNC_CLEAR: begin
              state_d = ST_CLEAR;
              cell_d  = '0;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_MAC: begin
        cell_d = cell_q + 1'b1;
        k_d    = k_q + 1'b1;
        if (k_last) begin
          k_d = '0;
          j_d = j_q + 1'b1;
        end
        sat_d = sat_q || mac_st.sat;
        if (cell_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        sat_d = sat_q || mac_st.sat;
        if (!mac_st.busy) begin
          state_d      = ST_IDLE;
          out_valid_d  = 1'b1;
          out_status_d = sat_q ? opa_pkg::STATUS_SATURATED : opa_pkg::STATUS_OK;
          out_value_d  = '0;
        end
      end
      ST_READ: begin
        state_d      = ST_IDLE;
        out_valid_d  = 1'b1;
        out_status_d = opa_pkg::STATUS_OK;
        out_value_d  = acc_rdata;
      end
      ST_CLEAR: begin
        cell_d = cell_q + 1'b1;
        if (cell_last) begin
          state_d      = ST_IDLE;
          out_valid_d  = 1'b1;
          out_status_d = opa_pkg::STATUS_OK;
          out_value_d  = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cell_q      <= '0;
      j_q         <= '0;
      k_q         <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cell_q      <= cell_d;
      j_q         <= j_d;
      k_q         <= k_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  // Stored vector table.
  assign tab_raddr = base_q + TAB_AW'(k_q);

  opa_ram #(
    .WIDTH (SW),
    .DEPTH (TAB_DEPTH),
    .AW    (TAB_AW)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_full[TAB_AW-1:0]),
    .wdata_i (sample_i),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  // Row buffer.
  opa_ram #(
    .WIDTH (SW),
    .DEPTH (DIM),
    .AW    (ROW_AW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (ROW_AW'(elem_a_i)),
    .wdata_i (sample_i),
    .raddr_i (j_q),
    .rdata_o (row_rdata)
  );

  // Multiply-accumulate pipeline.
  opa_mac #(
    .AW (ACC_AW)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (state_q == ST_MAC),
    .cell_i      (cell_q),
    .row_data_i  (row_rdata),
    .vec_data_i  (tab_rdata),
    .acc_raddr_o (mac_raddr),
    .acc_rdata_i (acc_rdata),
    .acc_we_o    (mac_we),
    .acc_waddr_o (mac_waddr),
    .acc_wdata_o (mac_wdata),
    .status_o    (mac_st)
  );

  // Accumulator memory: sweeps own the write port, cell reads own the read
  // port while idle, the pipeline uses both otherwise.
  assign acc_we    = sweep || mac_we;
  assign acc_waddr = sweep ? cell_q : mac_waddr;
  assign acc_wdata = sweep ? '0 : mac_wdata;
  assign acc_raddr = (state_q == ST_IDLE) ? cell_full[ACC_AW-1:0] : mac_raddr;

  opa_ram #(
    .WIDTH (AccW),
    .DEPTH (ACC_DEPTH),
    .AW    (ACC_AW)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // Result channel.
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign read_value_o = out_value_q;

endmodule
